>>> rtl/core/hla_pkg.sv
package hla_pkg;

    localparam int MAX_HOLES    = 1024;
    localparam int HEADER_BYTES = 4;
    localparam int IDX_W        = $clog2(MAX_HOLES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int SUM_W        = CNT_W + 32;

    localparam logic       CMD_ALLOC  = 1'b0;
    localparam logic       CMD_FREE   = 1'b1;
    localparam logic [1:0] POL_FIRST  = 2'd0;
    localparam logic [1:0] POL_BEST   = 2'd1;
    localparam logic [1:0] POL_WORST  = 2'd2;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic        command;
        logic [15:0] record_length;
        logic [31:0] free_offset;
    } req_t;

    typedef struct packed {
        logic [31:0] offset;
        logic        from_hole;
        logic [1:0]  status;
        logic [10:0] holes_now;
        logic [31:0] hole_bytes;
    } rsp_t;

    // one hole entry, size in the upper half so a packed compare orders (size, offset)
    typedef struct packed {
        logic [31:0] size;
        logic [31:0] off;
    } ent_t;

    function automatic logic is_sorted_pol(input logic [1:0] pol);
        return (pol == POL_BEST) || (pol == POL_WORST);
    endfunction

    function automatic logic goes_before(input ent_t a, input ent_t b, input logic [1:0] pol);
        logic r;
        if (pol == POL_BEST)
            r = (a < b);
        else
            r = (a > b);
        return r;
    endfunction

endpackage

>>> rtl/core/hla_ram.sv
module hla_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/hole_list_allocator_fit_policy.sv
// Hole-list space allocator with a first, best or worst fit policy.
// Request channel: drive req and raise start; the request is taken at a clock
// edge where start is high and busy is low. busy stays high until the result.
// Result channel: done is high for exactly one cycle with rsp valid; the
// receiver cannot stall it, so it must take the result in that cycle.
// Configuration: cfg_we with cfg_wdata writes fit_policy; write only while
// busy is low.
// Storage: all holes sit in one 1024-entry RAM with one read and one write
// port and a registered read, so every step walks the RAM. An allocate scans
// the list hole by hole up to the fit, then closes the gap entry by entry.
// Under best and worst fit a hole with a remainder is shrunk in place
// instead, and the list is then re-sorted by insertion sort, each entry
// compared with those before it. A free appends the hole, then sorts under
// best and worst fit; a free into a full list goes straight to the result.
// One request at a time.
// Reset clears the hole count, store end, byte total and policy; the RAM is
// not cleared since only entries below the count are ever used.
module hole_list_allocator_fit_policy (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  hla_pkg::req_t req,
    output logic          done,
    output hla_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_wdata
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_SCAN_RD  = 12'b000000000010,
        S_SCAN_CHK = 12'b000000000100,
        S_SH_RD    = 12'b000000001000,
        S_SH_WR    = 12'b000000010000,
        S_APPEND   = 12'b000000100000,
        S_SO_LD    = 12'b000001000000,
        S_SO_KEY   = 12'b000010000000,
        S_SO_RD    = 12'b000100000000,
        S_SO_CMP   = 12'b001000000000,
        S_SO_PUT   = 12'b010000000000,
        S_DONE     = 12'b100000000000
    } state_t;

    localparam int IW = hla_pkg::IDX_W;
    localparam int CW = hla_pkg::CNT_W;
    localparam int SW = hla_pkg::SUM_W;

    state_t            state_reg, state_next;
    logic [1:0]        pol_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [31:0]       store_end_reg, store_end_next;
    logic [SW-1:0]     total_reg, total_next;
    logic              cmd_reg, cmd_next;
    logic [31:0]       need_reg, need_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     j_reg, j_next;
    logic              app_after_reg, app_after_next;
    hla_pkg::ent_t     app_reg, app_next;
    hla_pkg::ent_t     key_reg, key_next;
    logic [31:0]       res_off_reg, res_off_next;
    logic              from_hole_reg, from_hole_next;
    logic [1:0]        status_reg, status_next;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr, mem_raddr;
    hla_pkg::ent_t     mem_wdata, mem_rdata;
    logic [32:0]       end_sum;
    logic [31:0]       rest;

    hla_ram #(.WIDTH($bits(hla_pkg::ent_t)), .DEPTH(hla_pkg::MAX_HOLES)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign end_sum = {1'b0, store_end_reg} + {1'b0, need_reg};
    assign rest    = mem_rdata.size - need_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pol_reg <= hla_pkg::POL_FIRST;
        else if (cfg_we)
            pol_reg <= cfg_wdata;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        store_end_next = store_end_reg;
        total_next     = total_reg;
        cmd_next       = cmd_reg;
        need_next      = need_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        app_after_next = app_after_reg;
        app_next       = app_reg;
        key_next       = key_reg;
        res_off_next   = res_off_reg;
        from_hole_next = from_hole_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = app_reg;
        mem_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next       = req.command;
                    need_next      = 32'(req.record_length) + 32'(hla_pkg::HEADER_BYTES);
                    from_hole_next = 1'b0;
                    status_next    = hla_pkg::ST_OK;
                    idx_next       = '0;
                    if (req.command == hla_pkg::CMD_FREE)
                    begin
                        res_off_next = req.free_offset;
                        app_next.size = 32'(req.record_length) + 32'(hla_pkg::HEADER_BYTES);
                        app_next.off  = req.free_offset;
                        if (app_next.size == '0)
                            state_next = S_DONE;
                        else if (count_reg >= CW'(hla_pkg::MAX_HOLES))
                        begin
                            status_next = hla_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                            state_next = S_APPEND;
                    end
                    else
                    begin
                        res_off_next = '0;
                        state_next   = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                mem_raddr = idx_reg[IW-1:0];
                if (idx_reg >= count_reg)
                begin
                    // no hole fits: take from the store end, or report overflow
                    if (end_sum[32] && end_sum[31:0] != '0)
                        status_next = hla_pkg::ST_OVERFLOW;
                    else
                    begin
                        res_off_next   = store_end_reg;
                        store_end_next = end_sum[31:0];
                    end
                    state_next = S_DONE;
                end
                else
                    state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (mem_rdata.size >= need_reg)
                begin
                    res_off_next   = mem_rdata.off;
                    from_hole_next = 1'b1;
                    total_next     = total_reg - SW'(need_reg);
                    app_next.size  = rest;
                    app_next.off   = mem_rdata.off + need_reg;
                    j_next         = idx_reg;
                    if (rest == '0)
                    begin
                        app_after_next = 1'b0;
                        state_next     = S_SH_RD;
                    end
                    else if (hla_pkg::is_sorted_pol(pol_reg))
                    begin
                        // shrink in place, then re-sort
                        mem_we         = 1'b1;
                        mem_waddr      = idx_reg[IW-1:0];
                        mem_wdata.size = rest;
                        mem_wdata.off  = mem_rdata.off + need_reg;
                        idx_next       = CW'(1);
                        state_next     = S_SO_LD;
                    end
                    else
                    begin
                        app_after_next = 1'b1;
                        state_next     = S_SH_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SH_RD:
            begin
                mem_raddr = IW'(j_reg + CW'(1));
                if (j_reg + CW'(1) >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = app_after_reg ? S_APPEND : S_DONE;
                end
                else
                    state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = j_reg[IW-1:0];
                mem_wdata  = mem_rdata;
                j_next     = j_reg + CW'(1);
                state_next = S_SH_RD;
            end
            S_APPEND:
            begin
                mem_we     = 1'b1;
                mem_waddr  = count_reg[IW-1:0];
                mem_wdata  = app_reg;
                count_next = count_reg + CW'(1);
                if (cmd_reg == hla_pkg::CMD_FREE)
                    total_next = total_reg + SW'(app_reg.size);
                idx_next = CW'(1);
                if (cmd_reg == hla_pkg::CMD_FREE && hla_pkg::is_sorted_pol(pol_reg))
                    state_next = S_SO_LD;
                else
                    state_next = S_DONE;
            end
            S_SO_LD:
            begin
                mem_raddr = idx_reg[IW-1:0];
                state_next = (idx_reg >= count_reg) ? S_DONE : S_SO_KEY;
            end
            S_SO_KEY:
            begin
                key_next   = mem_rdata;
                j_next     = idx_reg;
                state_next = S_SO_RD;
            end
            S_SO_RD:
            begin
                mem_raddr  = IW'(j_reg - CW'(1));
                state_next = S_SO_CMP;
            end
            S_SO_CMP:
            begin
                if (hla_pkg::goes_before(key_reg, mem_rdata, pol_reg))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = j_reg[IW-1:0];
                    mem_wdata  = mem_rdata;
                    j_next     = j_reg - CW'(1);
                    state_next = (j_reg == CW'(1)) ? S_SO_PUT : S_SO_RD;
                end
                else
                    state_next = S_SO_PUT;
            end
            S_SO_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = j_reg[IW-1:0];
                mem_wdata  = key_reg;
                idx_next   = idx_reg + CW'(1);
                state_next = S_SO_LD;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            store_end_reg <= '0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            store_end_reg <= store_end_next;
            total_reg     <= total_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        need_reg      <= need_next;
        idx_reg       <= idx_next;
        j_reg         <= j_next;
        app_after_reg <= app_after_next;
        app_reg       <= app_next;
        key_reg       <= key_next;
        res_off_reg   <= res_off_next;
        from_hole_reg <= from_hole_next;
        status_reg    <= status_next;
    end

    // result
    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_DONE);
    assign rsp.offset     = res_off_reg;
    assign rsp.from_hole  = from_hole_reg;
    assign rsp.status     = status_reg;
    assign rsp.holes_now  = 11'(count_reg);
    assign rsp.hole_bytes = (total_reg[SW-1:32] != '0) ? 32'hFFFF_FFFF : total_reg[31:0];

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(hla_pkg::MAX_HOLES))
        else $error("hole count above capacity");

    a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_CHK) |-> (idx_reg < count_reg))
        else $error("scan checked an entry past the list");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken without going busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned LEN_MAX     = 65535;

    typedef struct {
        hla_pkg::req_t r;
        int unsigned   gap;
    } pend_req_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    hla_pkg::req_t req;
    logic          done;
    hla_pkg::rsp_t rsp;
    logic          cfg_we;
    logic [1:0]    cfg_wdata;

    // request backlog for the driver and responses still owed by the block
    pend_req_t     req_backlog[$];
    hla_pkg::rsp_t owed_rsp[$];
    bit            req_taken;
    bit            holding;
    pend_req_t     held;
    int unsigned   hold_left;
    int unsigned   cycle_cnt;
    int unsigned   err_cnt;
    int unsigned   rsp_cnt;
    int unsigned   full_cnt;
    int unsigned   ovf_cnt;
    int unsigned   reuse_cnt;

    // allocator shadow state
    logic [1:0]  m_pol;
    logic [31:0] m_size[hla_pkg::MAX_HOLES];
    logic [31:0] m_off[hla_pkg::MAX_HOLES];
    int unsigned m_count;
    logic [31:0] m_end;
    logic [31:0] m_total;

    hole_list_allocator_fit_policy dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ordering of two holes under the sorted policies
    function automatic bit ahead(input logic [31:0] sa, input logic [31:0] oa,
                                 input logic [31:0] sb, input logic [31:0] ob,
                                 input logic [1:0] pol);
        if (pol == hla_pkg::POL_BEST)
            return (sa < sb) || (sa == sb && oa < ob);
        return (sa > sb) || (sa == sb && oa > ob);
    endfunction

    function automatic void reorder_holes();
        int unsigned i;
        int unsigned j;
        logic [31:0] s;
        logic [31:0] o;
        if (m_pol != hla_pkg::POL_BEST && m_pol != hla_pkg::POL_WORST)
            return;
        for (i = 1; i < m_count; i++)
        begin
            s = m_size[i];
            o = m_off[i];
            j = i;
            while (j > 0 && ahead(s, o, m_size[j-1], m_off[j-1], m_pol))
            begin
                m_size[j] = m_size[j-1];
                m_off[j]  = m_off[j-1];
                j--;
            end
            m_size[j] = s;
            m_off[j]  = o;
        end
    endfunction

    function automatic void drop_hole(input int unsigned idx);
        int unsigned j;
        for (j = idx; j + 1 < m_count; j++)
        begin
            m_size[j] = m_size[j+1];
            m_off[j]  = m_off[j+1];
        end
        m_count--;
    endfunction

    // apply one request to the shadow state and return the response it owes
    function automatic hla_pkg::rsp_t apply_request(input hla_pkg::req_t r);
        hla_pkg::rsp_t e;
        logic [31:0]   need;
        logic [31:0]   rest;
        logic [31:0]   rest_off;
        logic [63:0]   sum;
        int unsigned   i;
        bit            hit;
        need = 32'(r.record_length) + 32'(hla_pkg::HEADER_BYTES);
        e = '0;
        hit = 1'b0;
        if (r.command == hla_pkg::CMD_FREE)
        begin
            e.offset = r.free_offset;
            if (need != 0)
            begin
                if (m_count >= hla_pkg::MAX_HOLES)
                    e.status = hla_pkg::ST_FULL;
                else
                begin
                    m_size[m_count] = need;
                    m_off[m_count]  = r.free_offset;
                    m_count++;
                    reorder_holes();
                end
            end
        end
        else
        begin
            for (i = 0; i < m_count; i++)
            begin
                if (m_size[i] >= need)
                begin
                    hit = 1'b1;
                    break;
                end
            end
            if (hit)
            begin
                rest        = m_size[i] - need;
                rest_off    = m_off[i] + need;
                e.offset    = m_off[i];
                e.from_hole = 1'b1;
                if (rest == 0)
                    drop_hole(i);
                else if (m_pol == hla_pkg::POL_BEST || m_pol == hla_pkg::POL_WORST)
                begin
                    m_size[i] = rest;
                    m_off[i]  = rest_off;
                    reorder_holes();
                end
                else
                begin
                    drop_hole(i);
                    m_size[m_count] = rest;
                    m_off[m_count]  = rest_off;
                    m_count++;
                end
            end
            else if ({1'b0, m_end} + {1'b0, need} > 33'h1_0000_0000)
                e.status = hla_pkg::ST_OVERFLOW;
            else
            begin
                e.offset = m_end;
                m_end    = m_end + need;
            end
        end
        sum = '0;
        for (i = 0; i < m_count; i++)
            sum += m_size[i];
        m_total      = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        e.holes_now  = 11'(m_count);
        e.hole_bytes = m_total;
        return e;
    endfunction

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v,
                     act_v);
            err_cnt++;
        end
    endtask

    // monitor: check responses, then predict newly accepted requests
    always @(posedge clk)
    begin
        hla_pkg::rsp_t e;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb_top: timeout after %0d cycles", cycle_cnt);
            $display("tb_top: FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (owed_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, got 0x%0h", $time,
                             rsp);
                    err_cnt++;
                end
                else
                begin
                    e = owed_rsp.pop_front();
                    report_field("offset", e.offset, rsp.offset);
                    report_field("from_hole", 32'(e.from_hole), 32'(rsp.from_hole));
                    report_field("status", 32'(e.status), 32'(rsp.status));
                    report_field("holes_now", 32'(e.holes_now), 32'(rsp.holes_now));
                    report_field("hole_bytes", e.hole_bytes, rsp.hole_bytes);
                    rsp_cnt++;
                    if (e.status == hla_pkg::ST_FULL)
                        full_cnt++;
                    if (e.status == hla_pkg::ST_OVERFLOW)
                        ovf_cnt++;
                    if (e.from_hole)
                        reuse_cnt++;
                end
            end
            if (start && !busy)
            begin
                owed_rsp.push_back(apply_request(req));
                req_taken = 1'b1;
            end
        end
    end

    // driver: one request at a time, each after its own idle gap
    always @(negedge clk)
    begin
        bit go;
        if (rst_n && !(start && !req_taken))
        begin
            req_taken = 1'b0;
            go = 1'b0;
            if (!holding && req_backlog.size() > 0)
            begin
                held      = req_backlog.pop_front();
                holding   = 1'b1;
                hold_left = held.gap;
            end
            if (holding)
            begin
                if (hold_left == 0)
                begin
                    go      = 1'b1;
                    holding = 1'b0;
                end
                else
                    hold_left--;
            end
            start <= go;
            if (go)
                req <= held.r;
        end
    end

    task automatic queue_req(input logic cmd, input int unsigned len,
                             input logic [31:0] off, input int unsigned gap);
        pend_req_t p;
        p.r.command       = cmd;
        p.r.record_length = 16'(len);
        p.r.free_offset   = off;
        p.gap             = gap;
        req_backlog.push_back(p);
    endtask

    task automatic wait_idle();
        while (req_backlog.size() != 0 || holding || start || owed_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_policy(input logic [1:0] pol);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= pol;
        @(negedge clk);
        cfg_we <= 1'b0;
        m_pol = pol;
    endtask

    // random traffic: mostly small records so holes get reused
    task automatic random_reqs(input int unsigned n);
        int unsigned k;
        int unsigned len;
        int unsigned burst;
        logic        cmd;
        burst = $urandom_range(0, n);
        for (k = 0; k < n; k++)
        begin
            cmd = $urandom_range(0, 1);
            case ($urandom_range(0, 9)) inside
                0:       len = $urandom_range(0, LEN_MAX);
                1, 2:    len = $urandom_range(0, 3);
                default: len = $urandom_range(0, 255);
            endcase
            queue_req(cmd, len, $urandom,
                      (k >= burst && k < burst + 15) ? 0 : $urandom_range(0, 10));
        end
    endtask

    initial
    begin
        int unsigned i;
        int unsigned biggest;
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = hla_pkg::POL_FIRST;
        req_taken = 1'b0;
        holding   = 1'b0;
        hold_left = 0;
        cycle_cnt = 0;
        err_cnt   = 0;
        rsp_cnt   = 0;
        full_cnt  = 0;
        ovf_cnt   = 0;
        reuse_cnt = 0;
        m_pol     = hla_pkg::POL_FIRST;
        m_count   = 0;
        m_end     = '0;
        m_total   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed first fit: store end, exact fit, remainder, offset wrap
        set_policy(hla_pkg::POL_FIRST);
        queue_req(hla_pkg::CMD_ALLOC, 0, '0, 0);
        queue_req(hla_pkg::CMD_ALLOC, LEN_MAX, '0, 3);
        queue_req(hla_pkg::CMD_FREE, 0, 32'h0, 0);
        queue_req(hla_pkg::CMD_FREE, 60, 32'hFFFF_FFF0, 1);
        queue_req(hla_pkg::CMD_ALLOC, 28, 32'hFFFF_FFFF, 0);
        queue_req(hla_pkg::CMD_ALLOC, 0, '0, 2);
        queue_req(hla_pkg::CMD_FREE, LEN_MAX, 32'hFFFF_FFFF, 0);
        queue_req(hla_pkg::CMD_FREE, 100, 32'h1234_5678, 0);
        queue_req(hla_pkg::CMD_ALLOC, LEN_MAX, '0, 5);
        queue_req(hla_pkg::CMD_FREE, 20, 32'h0000_1000, 0);
        queue_req(hla_pkg::CMD_FREE, 20, 32'h0000_0800, 0);

        // sorted policies, the first free after each switch sorts the whole list
        set_policy(hla_pkg::POL_BEST);
        queue_req(hla_pkg::CMD_FREE, 8, 32'h0000_2000, 0);
        queue_req(hla_pkg::CMD_ALLOC, 10, '0, 0);
        queue_req(hla_pkg::CMD_ALLOC, 20, '0, 1);
        set_policy(hla_pkg::POL_WORST);
        queue_req(hla_pkg::CMD_FREE, 20, 32'h0000_0400, 0);
        queue_req(hla_pkg::CMD_ALLOC, 1, '0, 0);
        queue_req(hla_pkg::CMD_ALLOC, 20, '0, 0);
        set_policy(2'd3);
        queue_req(hla_pkg::CMD_FREE, 3, 32'h5555_AAAA, 0);
        queue_req(hla_pkg::CMD_ALLOC, 2, '0, 0);

        // random phases across every policy code
        random_reqs(45);
        set_policy(hla_pkg::POL_BEST);
        random_reqs(45);
        set_policy(hla_pkg::POL_WORST);
        random_reqs(45);
        set_policy(hla_pkg::POL_FIRST);
        random_reqs(40);
        set_policy(hla_pkg::POL_BEST);
        random_reqs(25);
        set_policy(hla_pkg::POL_WORST);
        random_reqs(25);

        // first fit: take back every hole that an exact fit can remove
        set_policy(hla_pkg::POL_FIRST);
        forever
        begin
            wait_idle();
            biggest = 0;
            for (i = 0; i < m_count; i++)
                if (m_size[i] > biggest)
                    biggest = m_size[i];
            if (biggest < hla_pkg::HEADER_BYTES)
                break;
            queue_req(hla_pkg::CMD_ALLOC, biggest - hla_pkg::HEADER_BYTES, $urandom, 0);
        end

        wait_idle();
        repeat (50) @(posedge clk);
        $display("tb_top: %0d responses checked, %0d from holes, %0d list full, %0d overflow",
                 rsp_cnt, reuse_cnt, full_cnt, ovf_cnt);
        $display("tb_top: all fit policies and the unused code, exact fit, offset wrap");
        if (err_cnt == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

>>> hole_list_allocator_fit_policy.f
rtl/core/hla_pkg.sv
rtl/core/hla_ram.sv
rtl/core/hole_list_allocator_fit_policy.sv
tb/tb_top.sv
